// ----- rtl/wheel_encoder_frame_receiver_unit_assert.svh -----
// Assertion helpers shared by the receiver's modules.
// Each macro expects signals named clk and rst_n in the enclosing module.
`ifndef WHEEL_ENCODER_FRAME_RECEIVER_UNIT_ASSERT_SVH
`define WHEEL_ENCODER_FRAME_RECEIVER_UNIT_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define WEFR_ASSERT_IMPL(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define WEFR_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/wefr_pkg.sv -----
package wefr_pkg;

    localparam int BYTE_W   = 8;
    localparam int COUNT_W  = 16;
    localparam int RATE_W   = 10;
    localparam int DELTA_W  = 26;
    localparam int DIV_STEPS = DELTA_W;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);
    localparam int TX_IDX_W  = 3;
    localparam int CFG_IDX_W = 1;

    // Frame bytes and message types.
    localparam logic [BYTE_W-1:0] SYNC1_BYTE   = 8'h55;
    localparam logic [BYTE_W-1:0] SYNC2_BYTE   = 8'hAA;
    localparam logic [BYTE_W-1:0] TYPE_SPEED   = 8'h01;
    localparam logic [BYTE_W-1:0] TYPE_ERROR   = 8'hFF;
    localparam logic [BYTE_W-1:0] SPEED_MIN_LEN = 8'd5;
    localparam logic [BYTE_W-1:0] RST_LEN_BYTE = 8'h02;
    localparam logic [BYTE_W-1:0] RST_CMD_BYTE = 8'h05;
    localparam logic [BYTE_W-1:0] RST_ARG_BYTE = 8'h00;
    localparam logic [TX_IDX_W-1:0] TX_LAST_IDX = 3'd6;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_SCALE_NUM = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SCALE_DEN = 1'd1;

    // Result kinds.
    localparam logic KIND_SPEED = 1'b0;
    localparam logic KIND_TX    = 1'b1;

    typedef enum logic [2:0] {
        PH_SYNC1,
        PH_SYNC2,
        PH_LEN,
        PH_SEQ,
        PH_PAYLOAD,
        PH_CHECK
    } phase_t;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_MUL,
        BK_LOAD,
        BK_DIV,
        BK_EMIT,
        BK_TX
    } bk_state_t;

    typedef enum logic {
        CMD_SPEED,
        CMD_RESET
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t          kind;
        logic [COUNT_W-1:0] left_count;
        logic [COUNT_W-1:0] right_count;
    } cmd_t;

    typedef struct packed {
        logic               kind;
        logic [DELTA_W-1:0] left_delta;
        logic [DELTA_W-1:0] right_delta;
        logic [BYTE_W-1:0]  tx_byte;
        logic               last;
    } result_t;

    // Byte idx of the reset frame 55 AA 02 seq 05 00 check.
    function automatic logic [BYTE_W-1:0] tx_frame_byte(
        input logic [TX_IDX_W-1:0] idx,
        input logic [BYTE_W-1:0]   seq
    );
        logic [BYTE_W-1:0] b;
        case (idx)
            3'd0:    b = SYNC1_BYTE;
            3'd1:    b = SYNC2_BYTE;
            3'd2:    b = RST_LEN_BYTE;
            3'd3:    b = seq;
            3'd4:    b = RST_CMD_BYTE;
            3'd5:    b = RST_ARG_BYTE;
            3'd6:    b = SYNC1_BYTE ^ SYNC2_BYTE ^ RST_LEN_BYTE ^ seq
                         ^ RST_CMD_BYTE ^ RST_ARG_BYTE;
            default: b = '0;
        endcase
        return b;
    endfunction

endpackage

// ----- rtl/wefr_front.sv -----
module wefr_front import wefr_pkg::*; (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              rx_valid,
    output logic              rx_ready,
    input  logic [BYTE_W-1:0] rx_byte,
    input  logic              q_full,
    output logic              push,
    output cmd_t              push_cmd
);

    localparam logic [BYTE_W-1:0] LAST_SPEED_POS = 8'd4;

    phase_t            phase_reg, phase_next;
    logic [BYTE_W-1:0] len_reg, len_next;
    logic [BYTE_W-1:0] count_reg, count_next;
    logic [BYTE_W-1:0] check_reg, check_next;
    logic [BYTE_W-1:0] type_reg, type_next;
    logic [BYTE_W-1:0] speed_reg [4];
    logic [BYTE_W-1:0] speed_next [4];
    logic              accept;
    logic [1:0]        speed_idx;
    logic [BYTE_W-1:0] count_inc;

    assign rx_ready  = !q_full;
    assign accept    = rx_valid && !q_full;
    assign speed_idx = 2'(count_reg - 8'd1);
    assign count_inc = count_reg + 8'd1;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            phase_reg <= PH_SYNC1;
            len_reg   <= '0;
            count_reg <= '0;
            check_reg <= '0;
            type_reg  <= '0;
        end else begin
            phase_reg <= phase_next;
            len_reg   <= len_next;
            count_reg <= count_next;
            check_reg <= check_next;
            type_reg  <= type_next;
        end
    end

    always_ff @(posedge clk) begin
        speed_reg <= speed_next;
    end

    always_comb begin
        phase_next = phase_reg;
        len_next   = len_reg;
        count_next = count_reg;
        check_next = check_reg;
        type_next  = type_reg;
        speed_next = speed_reg;
        push       = 1'b0;
        push_cmd.kind        = CMD_SPEED;
        push_cmd.left_count  = {speed_reg[0], speed_reg[1]};
        push_cmd.right_count = {speed_reg[2], speed_reg[3]};

        if (accept) begin
            case (phase_reg)
                PH_SYNC1: begin
                    if (rx_byte == SYNC1_BYTE) begin
                        check_next = rx_byte;
                        phase_next = PH_SYNC2;
                    end
                end
                PH_SYNC2: begin
                    if (rx_byte == SYNC2_BYTE) begin
                        check_next = check_reg ^ rx_byte;
                        phase_next = PH_LEN;
                    end else begin
                        phase_next = PH_SYNC1;
                    end
                end
                PH_LEN: begin
                    check_next = check_reg ^ rx_byte;
                    len_next   = rx_byte;
                    count_next = '0;
                    type_next  = '0;
                    phase_next = PH_SEQ;
                end
                PH_SEQ: begin
                    check_next = check_reg ^ rx_byte;
                    phase_next = (len_reg == '0) ? PH_CHECK : PH_PAYLOAD;
                end
                PH_PAYLOAD: begin
                    check_next = check_reg ^ rx_byte;
                    if (count_reg == '0) begin
                        type_next = rx_byte;
                    end else if (count_reg <= LAST_SPEED_POS) begin
                        speed_next[speed_idx] = rx_byte;
                    end
                    count_next = count_inc;
                    if (count_inc == len_reg) begin
                        phase_next = PH_CHECK;
                    end
                end
                PH_CHECK: begin
                    phase_next = PH_SYNC1;
                    if (rx_byte == check_reg) begin
                        if (type_reg == TYPE_SPEED && len_reg >= SPEED_MIN_LEN) begin
                            push = 1'b1;
                        end else if (type_reg == TYPE_ERROR) begin
                            push          = 1'b1;
                            push_cmd.kind = CMD_RESET;
                        end
                    end
                end
                default: begin
                    phase_next = PH_SYNC1;
                end
            endcase
        end
    end

endmodule

// ----- rtl/wefr_queue.sv -----
`include "wheel_encoder_frame_receiver_unit_assert.svh"

module wefr_queue import wefr_pkg::*; #(
    parameter int DEPTH = 2
) (
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t push_cmd,
    output logic full,
    input  logic pop,
    output cmd_t head_cmd,
    output logic empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    cmd_t             mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    assign full     = (cnt_reg == FULL_CNT);
    assign empty    = (cnt_reg == '0);
    assign head_cmd = mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            cnt_next = cnt_reg + 1'b1;
        end else if (pop && !push) begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    `WEFR_ASSERT_IMPL(a_no_push_when_full, push, !full || pop, "queue written while full")
    `WEFR_ASSERT_IMPL(a_no_pop_when_empty, pop, !empty, "queue read while empty")
    `WEFR_ASSERT_NEXT(a_count_tracks, push && !pop, cnt_reg == $past(cnt_reg) + 1'b1, "queue count did not advance")

endmodule

// ----- rtl/wefr_div.sv -----
module wefr_div import wefr_pkg::*; (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [DELTA_W-1:0] dividend,
    input  logic [RATE_W-1:0]  divisor,
    output logic               done,
    output logic [DELTA_W-1:0] quotient
);

    localparam logic [DIV_CNT_W-1:0] FIRST_CNT = DIV_CNT_W'(DIV_STEPS - 1);

    logic                 busy_reg, busy_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [DELTA_W-1:0]   q_reg, q_next;
    logic [RATE_W-1:0]    r_reg, r_next;
    logic [RATE_W:0]      trial;
    logic [RATE_W:0]      diff;
    logic                 fits;

    assign trial    = {r_reg, q_reg[DELTA_W-1]};
    assign diff     = trial - {1'b0, divisor};
    assign fits     = (trial >= {1'b0, divisor});
    assign done     = busy_reg && (cnt_reg == '0);
    assign quotient = q_reg;

    // Restoring division, one quotient bit per cycle.
    always_comb begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        q_next    = q_reg;
        r_next    = r_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = FIRST_CNT;
            q_next    = dividend;
            r_next    = '0;
        end else if (busy_reg) begin
            q_next = {q_reg[DELTA_W-2:0], fits};
            r_next = fits ? diff[RATE_W-1:0] : trial[RATE_W-1:0];
            if (cnt_reg == '0) begin
                busy_next = 1'b0;
            end else begin
                cnt_next = cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk) begin
        q_reg <= q_next;
        r_reg <= r_next;
    end

endmodule

// ----- rtl/wefr_back.sv -----
`include "wheel_encoder_frame_receiver_unit_assert.svh"

module wefr_back import wefr_pkg::*; (
    input  logic              clk,
    input  logic              rst_n,
    input  logic [RATE_W-1:0] scale_num,
    input  logic [RATE_W-1:0] scale_den,
    input  logic              q_empty,
    input  cmd_t              head_cmd,
    output logic              q_pop,
    output logic              res_valid,
    input  logic              res_ready,
    output result_t           res
);

    localparam int PROD_W = COUNT_W + RATE_W + 1;

    bk_state_t           state_reg, state_next;
    cmd_t                cmd_reg, cmd_next;
    logic [COUNT_W-1:0]  left_count_reg, left_count_next;
    logic [COUNT_W-1:0]  right_count_reg, right_count_next;
    logic [BYTE_W-1:0]   tx_seq_reg, tx_seq_next;
    logic [TX_IDX_W-1:0] tx_idx_reg, tx_idx_next;
    logic [DELTA_W-1:0]  mag_l_reg, mag_l_next;
    logic [DELTA_W-1:0]  mag_r_reg, mag_r_next;
    logic                neg_l_reg, neg_l_next;
    logic                neg_r_reg, neg_r_next;
    logic                out_valid_reg, out_valid_next;
    result_t             out_reg, out_next;

    logic signed [COUNT_W-1:0] delta_l, delta_r;
    logic signed [PROD_W-1:0]  prod_l, prod_r;
    logic                      slot_free;
    logic                      div_start;
    logic                      done_l, done_r;
    logic [DELTA_W-1:0]        quot_l, quot_r;
    logic [DELTA_W-1:0]        signed_l, signed_r;

    assign delta_l   = $signed(cmd_reg.left_count - left_count_reg);
    assign delta_r   = $signed(cmd_reg.right_count - right_count_reg);
    assign prod_l    = delta_l * $signed({1'b0, scale_num});
    assign prod_r    = delta_r * $signed({1'b0, scale_num});
    assign slot_free = !out_valid_reg || res_ready;
    assign div_start = (state_reg == BK_LOAD);
    assign signed_l  = neg_l_reg ? (~quot_l + 1'b1) : quot_l;
    assign signed_r  = neg_r_reg ? (~quot_r + 1'b1) : quot_r;
    assign res_valid = out_valid_reg;
    assign res       = out_reg;

    wefr_div u_div_left (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (mag_l_reg),
        .divisor  (scale_den),
        .done     (done_l),
        .quotient (quot_l)
    );

    wefr_div u_div_right (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (mag_r_reg),
        .divisor  (scale_den),
        .done     (done_r),
        .quotient (quot_r)
    );

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            state_reg       <= BK_IDLE;
            left_count_reg  <= '0;
            right_count_reg <= '0;
            tx_seq_reg      <= '0;
            tx_idx_reg      <= '0;
            out_valid_reg   <= 1'b0;
        end else begin
            state_reg       <= state_next;
            left_count_reg  <= left_count_next;
            right_count_reg <= right_count_next;
            tx_seq_reg      <= tx_seq_next;
            tx_idx_reg      <= tx_idx_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk) begin
        cmd_reg   <= cmd_next;
        mag_l_reg <= mag_l_next;
        mag_r_reg <= mag_r_next;
        neg_l_reg <= neg_l_next;
        neg_r_reg <= neg_r_next;
        out_reg   <= out_next;
    end

    always_comb begin
        state_next       = state_reg;
        cmd_next         = cmd_reg;
        left_count_next  = left_count_reg;
        right_count_next = right_count_reg;
        tx_seq_next      = tx_seq_reg;
        tx_idx_next      = tx_idx_reg;
        mag_l_next       = mag_l_reg;
        mag_r_next       = mag_r_reg;
        neg_l_next       = neg_l_reg;
        neg_r_next       = neg_r_reg;
        out_next         = out_reg;
        out_valid_next   = out_valid_reg && !res_ready;
        q_pop            = 1'b0;

        case (state_reg)
            BK_IDLE: begin
                if (!q_empty) begin
                    q_pop       = 1'b1;
                    cmd_next    = head_cmd;
                    tx_idx_next = '0;
                    state_next  = (head_cmd.kind == CMD_SPEED) ? BK_MUL : BK_TX;
                end
            end
            BK_MUL: begin
                // Work on magnitudes so that the division truncates toward zero.
                neg_l_next = prod_l[PROD_W-1];
                neg_r_next = prod_r[PROD_W-1];
                mag_l_next = prod_l[PROD_W-1] ? (~prod_l[DELTA_W-1:0] + 1'b1)
                                              : prod_l[DELTA_W-1:0];
                mag_r_next = prod_r[PROD_W-1] ? (~prod_r[DELTA_W-1:0] + 1'b1)
                                              : prod_r[DELTA_W-1:0];
                left_count_next  = cmd_reg.left_count;
                right_count_next = cmd_reg.right_count;
                state_next       = BK_LOAD;
            end
            BK_LOAD: begin
                state_next = BK_DIV;
            end
            BK_DIV: begin
                if (done_l) begin
                    state_next = BK_EMIT;
                end
            end
            BK_EMIT: begin
                if (slot_free) begin
                    out_valid_next       = 1'b1;
                    out_next.kind        = KIND_SPEED;
                    out_next.left_delta  = (scale_den == '0) ? '0 : signed_l;
                    out_next.right_delta = (scale_den == '0) ? '0 : signed_r;
                    out_next.tx_byte     = '0;
                    out_next.last        = 1'b1;
                    state_next           = BK_IDLE;
                end
            end
            BK_TX: begin
                if (slot_free) begin
                    out_valid_next       = 1'b1;
                    out_next.kind        = KIND_TX;
                    out_next.left_delta  = '0;
                    out_next.right_delta = '0;
                    out_next.tx_byte     = tx_frame_byte(tx_idx_reg, tx_seq_reg);
                    out_next.last        = (tx_idx_reg == TX_LAST_IDX);
                    tx_idx_next          = tx_idx_reg + 1'b1;
                    if (tx_idx_reg == TX_LAST_IDX) begin
                        tx_seq_next = tx_seq_reg + 1'b1;
                        state_next  = BK_IDLE;
                    end
                end
            end
            default: begin
                state_next = BK_IDLE;
            end
        endcase
    end

    `WEFR_ASSERT_IMPL(a_pop_only_idle, q_pop, state_reg == BK_IDLE, "command taken while busy")
    `WEFR_ASSERT_IMPL(a_lanes_in_step, 1'b1, done_l == done_r, "divider lanes out of step")
    `WEFR_ASSERT_IMPL(a_done_in_div, done_l, state_reg == BK_DIV, "divider finished outside its wait")
    `WEFR_ASSERT_IMPL(a_speed_is_last, out_valid_reg && out_reg.kind == KIND_SPEED, out_reg.last, "speed word not marked last")

endmodule

// ----- rtl/wheel_encoder_frame_receiver_unit.sv -----
// Wheel encoder frame receiver. Received serial bytes come in one word at a time on the
// slave stream and are parsed into frames of the form 0x55, 0xAA, length, sequence, payload
// (first byte the message type) and an XOR check byte; frames whose check fails are dropped
// without trace. A valid speed frame (type 0x01, length of at least five) yields one word of
// kind 0 carrying both wheels' wrapped 16-bit count changes, each multiplied by the scale
// numerator register and divided by the scale denominator register, truncated toward zero
// (zero when the denominator is zero). A valid error frame (type 0xFF) yields seven words of
// kind 1, the bytes of a reset frame to transmit, with a sequence number that counts up per
// reset frame. tlast marks the final word caused by an input byte. Input bytes are taken one
// per cycle as long as the command queue between the parser and the execution side has room.
// A speed frame takes the execution side through taking the command, multiplying, loading
// and running the restoring divider, and emitting; a reset frame takes the command and then
// emits one byte per cycle when the output is not stalled. The output word sits in a register
// of its own, so the next result is prepared while the previous one waits.
module wheel_encoder_frame_receiver_unit import wefr_pkg::*; #(
    // Frame commands that may wait between the parser and the execution side.
    parameter int QUEUE_DEPTH = 2
) (
    input  logic                 clk,
    input  logic                 rst_n,

    // Received bytes. tdata: [7:0] rx_byte.
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [7:0]           s_axis_tdata,

    // Results. tdata: [25:0] left_delta, [51:26] right_delta, [59:52] tx_byte,
    // [63:60] zero. tuser: [0] kind. tlast: last.
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [63:0]          m_axis_tdata,
    output logic [0:0]           m_axis_tuser,
    output logic                 m_axis_tlast,

    // Register writes: index 0 scale numerator, index 1 scale denominator.
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [RATE_W-1:0]    cfg_data
);

    localparam int PAD_W = 64 - (2 * DELTA_W + BYTE_W);

    logic [RATE_W-1:0] scale_num_reg;
    logic [RATE_W-1:0] scale_den_reg;
    logic              q_full;
    logic              q_empty;
    logic              q_push;
    logic              q_pop;
    cmd_t              push_cmd;
    cmd_t              head_cmd;
    result_t           res;

    // The user must write the rate registers only while nothing is in flight; the block does not enforce this.
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            scale_num_reg <= 10'd10;
            scale_den_reg <= 10'd50;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_SCALE_NUM: scale_num_reg <= cfg_data;
                REG_SCALE_DEN: scale_den_reg <= cfg_data;
                default:       ;
            endcase
        end
    end

    // Front: frame parser, pushes one command per valid frame that causes any result.
    wefr_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .rx_valid (s_axis_tvalid),
        .rx_ready (s_axis_tready),
        .rx_byte  (s_axis_tdata),
        .q_full   (q_full),
        .push     (q_push),
        .push_cmd (push_cmd)
    );

    wefr_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_cmd (push_cmd),
        .full     (q_full),
        .pop      (q_pop),
        .head_cmd (head_cmd),
        .empty    (q_empty)
    );

    // Back: delta scaling and reset frame generation, with the output register.
    wefr_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .scale_num    (scale_num_reg),
        .scale_den    (scale_den_reg),
        .q_empty      (q_empty),
        .head_cmd     (head_cmd),
        .q_pop        (q_pop),
        .res_valid    (m_axis_tvalid),
        .res_ready    (m_axis_tready),
        .res          (res)
    );

    assign m_axis_tdata = {{PAD_W{1'b0}}, res.tx_byte, res.right_delta, res.left_delta};
    assign m_axis_tuser = res.kind;
    assign m_axis_tlast = res.last;

endmodule
